// File: hdl/waypoint_heading_controller_unit_assert.svh
// Assertion macros for the waypoint heading controller.
// Used by the port checker; no other dependencies.
`ifndef WAYPOINT_HEADING_CONTROLLER_UNIT_ASSERT_SVH
`define WAYPOINT_HEADING_CONTROLLER_UNIT_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define WHC_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define WHC_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: hdl/whc_pkg.sv
// Shared constants and types for the waypoint heading controller.
// No dependencies.
package whc_pkg;
  localparam int QueueDepthDef  = 16;
  localparam int CordicStepsDef = 16;
  localparam logic signed [17:0] PiQ13     = 18'sd25736;
  localparam logic signed [17:0] TwoPiQ13  = 18'sd51472;
  localparam logic signed [17:0] HalfPiQ13 = 18'sd12868;

  typedef enum logic [2:0] {
    ST_NO_WP   = 3'd0,
    ST_TRACK   = 3'd1,
    ST_REACHED = 3'd2,
    ST_DONE    = 3'd3,
    ST_ACCEPT  = 3'd4,
    ST_NO_POSE = 3'd5,
    ST_FULL    = 3'd6
  } status_t;

  localparam logic [2:0] REG_POS_TOL  = 3'd0;
  localparam logic [2:0] REG_HEAD_TOL = 3'd1;
  localparam logic [2:0] REG_LIN_MAX  = 3'd2;
  localparam logic [2:0] REG_ANG_GAIN = 3'd3;
  localparam logic [2:0] REG_LIN_STEP = 3'd4;

  function automatic logic signed [17:0] atan_q13(input logic [4:0] i);
    case (i)
      5'd0: atan_q13 = 18'sd6434;
      5'd1: atan_q13 = 18'sd3798;
      5'd2: atan_q13 = 18'sd2007;
      5'd3: atan_q13 = 18'sd1019;
      5'd4: atan_q13 = 18'sd511;
      5'd5: atan_q13 = 18'sd256;
      5'd6: atan_q13 = 18'sd128;
      5'd7: atan_q13 = 18'sd64;
      5'd8: atan_q13 = 18'sd32;
      5'd9: atan_q13 = 18'sd16;
      5'd10: atan_q13 = 18'sd8;
      5'd11: atan_q13 = 18'sd4;
      5'd12: atan_q13 = 18'sd2;
      5'd13: atan_q13 = 18'sd1;
      default: atan_q13 = 18'sd0;
    endcase
  endfunction
endpackage

// File: hdl/whc_cordic.sv
// Iterative CORDIC vectoring unit: atan2(y, x) in signed Q4.13, one step a cycle.
// Depends on whc_pkg.
module whc_cordic #(
  parameter int CordicSteps = whc_pkg::CordicStepsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [33:0] y_in,
  input  logic signed [33:0] x_in,
  output logic               done,
  output logic signed [17:0] angle
);
  // growth over the steps stays below a factor of 1.65 plus one bit of headroom
  localparam int W = 37;
  logic signed [W-1:0] x_r, y_r;
  logic signed [17:0]  z_r;
  logic [4:0]          i_r;
  logic                busy_r, done_r;
  logic signed [W-1:0] xs, ys, xe, ye;

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign xe = W'(x_in);
  assign ye = W'(y_in);
  assign done = done_r;
  assign angle = z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        i_r <= '0;
        if (x_in == 0 && y_in == 0) begin
          z_r <= '0;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          if (x_in < 0) begin
            if (y_in >= 0) begin
              x_r <= ye; y_r <= -xe; z_r <= whc_pkg::HalfPiQ13;
            end else begin
              x_r <= -ye; y_r <= xe; z_r <= -whc_pkg::HalfPiQ13;
            end
          end else begin
            x_r <= xe; y_r <= ye; z_r <= '0;
          end
        end
      end else if (busy_r) begin
        if (y_r > 0) begin
          x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + whc_pkg::atan_q13(i_r);
        end else begin
          x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - whc_pkg::atan_q13(i_r);
        end
        i_r <= i_r + 5'd1;
        if (32'(i_r) == CordicSteps - 1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

// File: hdl/waypoint_heading_controller_unit.sv
// Waypoint heading controller for a differential-drive robot.
// Channels: in_ stream carries pose updates (cmd 0) and waypoint appends
// (cmd 1); out_ stream returns one result beat per input beat; cfg_ is a
// plain register write port (index 0..4), to be used only while idle; the
// block does not enforce this. A waypoint append passes through S_APPEND
// and S_OUT to its result; a pose update with an empty queue registers its
// result on acceptance. A pose update with waypoints queued runs the shared
// CORDIC unit twice (bearing, then yaw), then wraps the heading error and
// does a gain multiply and a distance check through one shared 32x32
// multiplier. The block takes one item at a time; in_tready is low from
// acceptance until the result is taken.
// Reset clears the queue, the pose flag and the forward speed, and loads
// the register defaults. Waypoint storage is not cleared. When the
// receiver holds out_tready low the result beat holds and no new item is
// accepted.
module waypoint_heading_controller_unit #(
  parameter int QueueDepth  = whc_pkg::QueueDepthDef,
  parameter int CordicSteps = whc_pkg::CordicStepsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pos_x[31:0], pos_y[63:32], quat_x[79:64], quat_y[95:80], quat_z[111:96],
  // quat_w[127:112]
  input  logic [127:0] in_tdata,
  // cmd
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], angular_speed[18:3], linear_speed[33:19], target_x[65:34],
  // target_y[97:66], waypoints_left[102:98], zero fill to 103
  output logic [103:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);
  localparam int AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CW = $clog2(QueueDepth + 1);
  localparam int SW = AW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_APPEND, S_BEAR_GO, S_BEAR_WAIT, S_YAW_GO, S_YAW_WAIT,
    S_ERR, S_MUL_ANG, S_MUL_DX, S_MUL_DY, S_MUL_TOL, S_FINISH, S_OUT
  } state_t;

  state_t state_r;
  logic [30:0] pos_tol_r;
  logic [14:0] head_tol_r, lin_max_r, ang_gain_r, lin_step_r;
  logic [AW-1:0] head_r;
  logic [CW-1:0] count_r;
  logic pose_seen_r;
  logic [14:0] fwd_r;
  logic [63:0] store_r [QueueDepth];
  logic [63:0] rd_r;
  logic signed [31:0] px_r, py_r;
  logic signed [15:0] qx_r, qy_r, qz_r, qw_r;
  logic signed [18:0] bear_r;
  logic signed [18:0] err_r;
  logic signed [63:0] prod_r;
  logic [64:0] dsum_r;
  logic far_r;
  logic [2:0] st_out_r;
  logic signed [15:0] ang_out_r;
  logic [14:0] lin_out_r;
  logic signed [31:0] tx_out_r, ty_out_r;
  logic [4:0] left_out_r;
  logic out_valid_r;

  // CORDIC operands
  logic cor_start;
  logic signed [33:0] cor_y, cor_x;
  logic cor_done;
  logic signed [17:0] cor_angle;
  logic signed [32:0] dx, dy;
  logic signed [33:0] sy, cy;

  assign dx = 33'(signed'(rd_r[31:0])) - 33'(px_r);
  assign dy = 33'(signed'(rd_r[63:32])) - 33'(py_r);
  // 16x16 products are exact in 32 bits; sums and doubling need 34
  assign sy = (34'(32'(qw_r) * 32'(qz_r)) + 34'(32'(qx_r) * 32'(qy_r))) <<< 1;
  assign cy = 34'sd268435456 -
              ((34'(32'(qy_r) * 32'(qy_r)) + 34'(32'(qz_r) * 32'(qz_r))) <<< 1);
  assign cor_start = (state_r == S_BEAR_GO) || (state_r == S_YAW_GO);
  assign cor_y = (state_r == S_BEAR_GO) ? 34'(dy) : sy;
  assign cor_x = (state_r == S_BEAR_GO) ? 34'(dx) : cy;

  whc_cordic #(.CordicSteps(CordicSteps)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cor_start), .y_in(cor_y), .x_in(cor_x),
    .done(cor_done), .angle(cor_angle)
  );

  // shared multiplier: 32x32 unsigned product of magnitudes (abs operands < 2^32)
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [32:0] adx, ady;
  logic signed [18:0] abs_err;
  assign adx = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady = dy[32] ? 33'(-dy) : 33'(dy);
  assign abs_err = err_r[18] ? -err_r : err_r;
  always_comb begin
    unique case (state_r)
      S_MUL_ANG: begin mul_a = 32'(abs_err); mul_b = 32'(ang_gain_r); end
      S_MUL_DX:  begin mul_a = adx[31:0]; mul_b = adx[31:0]; end
      S_MUL_DY:  begin mul_a = ady[31:0]; mul_b = ady[31:0]; end
      S_MUL_TOL: begin mul_a = 32'(pos_tol_r); mul_b = 32'(pos_tol_r); end
      default:   begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  logic signed [18:0] werr;
  logic signed [19:0] raw_err;
  assign raw_err = 20'(bear_r) - 20'(cor_angle);
  always_comb begin
    if (raw_err > 20'(whc_pkg::PiQ13)) werr = 19'(raw_err - 20'(whc_pkg::TwoPiQ13));
    else if (raw_err < -20'(whc_pkg::PiQ13)) werr = 19'(raw_err + 20'(whc_pkg::TwoPiQ13));
    else werr = 19'(raw_err);
  end

  logic signed [64:0] sprod, shifted, gain_s;
  logic signed [15:0] ang_clamp;
  assign sprod = err_r[18] ? -65'(prod_r) : 65'(prod_r);
  assign shifted = (sprod + 65'sd4096) >>> 13;
  assign gain_s = signed'(65'(ang_gain_r));
  always_comb begin
    if (shifted > gain_s) ang_clamp = 16'(ang_gain_r);
    else if (shifted < -gain_s) ang_clamp = -16'(ang_gain_r);
    else ang_clamp = 16'(shifted);
  end
  logic [15:0] fwd_sum;
  assign fwd_sum = 16'(fwd_r) + 16'(lin_step_r);

  logic [CW-1:0] cnt_dec;
  logic [AW-1:0] slot;
  logic [SW-1:0] slot_sum;
  logic [AW-1:0] head_inc;
  assign cnt_dec = count_r - CW'(1);
  // head + count stays below twice the depth: one subtract wraps it
  assign slot_sum = SW'(head_r) + SW'(count_r);
  assign slot = (slot_sum >= SW'(QueueDepth)) ? AW'(slot_sum - SW'(QueueDepth))
                                              : AW'(slot_sum);
  assign head_inc = (32'(head_r) == QueueDepth - 1) ? '0 : head_r + AW'(1);

  assign in_tready = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata = {1'b0, left_out_r, ty_out_r, tx_out_r, lin_out_r, ang_out_r, st_out_r};

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (in_acc) rd_r <= store_r[head_r];
    else if (state_r == S_APPEND && pose_seen_r && 32'(count_r) < QueueDepth)
      store_r[slot] <= {py_r, px_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_tol_r <= 31'd32768;
      head_tol_r <= 15'd2048;
      lin_max_r <= 15'd256;
      ang_gain_r <= 15'd256;
      lin_step_r <= 15'd16;
      head_r <= '0;
      count_r <= '0;
      pose_seen_r <= 1'b0;
      fwd_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          whc_pkg::REG_POS_TOL:  pos_tol_r <= cfg_data;
          whc_pkg::REG_HEAD_TOL: head_tol_r <= cfg_data[14:0];
          whc_pkg::REG_LIN_MAX:  lin_max_r <= cfg_data[14:0];
          whc_pkg::REG_ANG_GAIN: ang_gain_r <= cfg_data[14:0];
          whc_pkg::REG_LIN_STEP: lin_step_r <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_acc) begin
          px_r <= in_tdata[31:0];
          py_r <= in_tdata[63:32];
          qx_r <= in_tdata[79:64];
          qy_r <= in_tdata[95:80];
          qz_r <= in_tdata[111:96];
          qw_r <= in_tdata[127:112];
          if (in_tuser) state_r <= S_APPEND;
          else begin
            pose_seen_r <= 1'b1;
            if (count_r == 0) begin
              st_out_r <= whc_pkg::ST_NO_WP;
              ang_out_r <= '0; lin_out_r <= '0; tx_out_r <= '0; ty_out_r <= '0;
              left_out_r <= 5'(count_r);
              out_valid_r <= 1'b1;
            end else state_r <= S_BEAR_GO;
          end
        end
        S_APPEND: begin
          tx_out_r <= px_r; ty_out_r <= py_r;
          ang_out_r <= '0; lin_out_r <= '0;
          if (!pose_seen_r) begin
            st_out_r <= whc_pkg::ST_NO_POSE; left_out_r <= 5'(count_r);
          end else if (32'(count_r) >= QueueDepth) begin
            st_out_r <= whc_pkg::ST_FULL; left_out_r <= 5'(count_r);
          end else begin
            st_out_r <= whc_pkg::ST_ACCEPT;
            count_r <= count_r + CW'(1);
            left_out_r <= 5'(count_r + CW'(1));
          end
          state_r <= S_OUT;
        end
        S_BEAR_GO: state_r <= S_BEAR_WAIT;
        S_BEAR_WAIT: if (cor_done) begin
          bear_r <= 19'(cor_angle);
          state_r <= S_YAW_GO;
        end
        S_YAW_GO: state_r <= S_YAW_WAIT;
        S_YAW_WAIT: if (cor_done) begin
          err_r <= werr;
          state_r <= S_ERR;
        end
        S_ERR: begin
          // forward speed ramp
          if (abs_err < 19'(head_tol_r))
            fwd_r <= (fwd_sum > 16'(lin_max_r)) ? lin_max_r : fwd_sum[14:0];
          else fwd_r <= '0;
          far_r <= adx[32] || ady[32] || adx[31] || ady[31];
          state_r <= S_MUL_ANG;
        end
        S_MUL_ANG: begin prod_r <= mul_p; state_r <= S_MUL_DX; end
        S_MUL_DX: begin
          ang_out_r <= ang_clamp;
          dsum_r <= 65'(mul_p);
          state_r <= S_MUL_DY;
        end
        S_MUL_DY: begin dsum_r <= dsum_r + 65'(mul_p); state_r <= S_MUL_TOL; end
        S_MUL_TOL: begin
          tx_out_r <= rd_r[31:0];
          ty_out_r <= rd_r[63:32];
          lin_out_r <= fwd_r;
          if (!far_r && dsum_r < 65'(mul_p)) begin
            head_r <= head_inc;
            count_r <= cnt_dec;
            left_out_r <= 5'(cnt_dec);
            st_out_r <= (cnt_dec == 0) ? whc_pkg::ST_DONE : whc_pkg::ST_REACHED;
          end else begin
            left_out_r <= 5'(count_r);
            st_out_r <= whc_pkg::ST_TRACK;
          end
          state_r <= S_FINISH;
        end
        S_FINISH: state_r <= S_OUT;
        S_OUT: begin out_valid_r <= 1'b1; state_r <= S_IDLE; end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hdl/whc_checker.sv
// Port-level checker for the waypoint heading controller, bound to the top.
// Depends on waypoint_heading_controller_unit_assert.svh.
`include "waypoint_heading_controller_unit_assert.svh"
module whc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata
);
  `WHC_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `WHC_ASSERT_IMP(a_no_accept_while_out, clk, rst_n, out_tvalid, !in_tready)
  `WHC_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `WHC_ASSERT_IMP(a_status_range, clk, rst_n, out_tvalid, out_tdata[2:0] != 3'd7)
endmodule

bind waypoint_heading_controller_unit whc_checker u_whc_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
